### hdl/sbc_pkg.sv
// sbc_pkg: shared constants and types of the sphere/box contact pipeline.
// Used by sbc_front, sbc_sqrt, sbc_div and sphere_box_contact.
package sbc_pkg;

  // Normalizing: largest component lands with its top bit here
  localparam int NormTop   = 23;
  localparam int A_W       = NormTop + 1;       // scaled component magnitude
  localparam int LEN2_W    = 2 * A_W + 2;       // sum of three squares
  localparam int ROOT_W    = LEN2_W / 2;        // floor square root
  localparam int REM_W     = ROOT_W + 2;        // root remainder
  localparam int FracSh    = 14;                // Q2.14 normal fraction bits
  localparam int Q_W       = FracSh + 1;        // quotient magnitude, up to 1.0
  localparam int NRM_W     = 16;                // signed normal component
  localparam int DREM_W    = ROOT_W + 1;        // divider remainder
  localparam int RndHalf   = 1 << (FracSh - 1);

  // Iteration split over register stages
  localparam int SqrtSteps = 5;
  localparam int SqrtStg   = ROOT_W / SqrtSteps;
  localparam int DivSteps  = 3;
  localparam int DivStg    = Q_W / DivSteps;

  // Per-item decision flags that follow the data down the pipe
  typedef struct packed {
    logic miss;      // sphere does not touch the box
    logic enclosed;  // center inside the box on every axis
    logic zero;      // vector to normalize is all zero
  } item_flags_t;

endpackage

### hdl/sbc_front.sv
// sbc_front: classify, clamp, miss test and normalize prescale (six stages).
// Depends on sbc_pkg.
module sbc_front #(
  parameter int CoordBits = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  logic                          vld_i,
  input  logic signed [CoordBits-1:0]   ctr_i [3],
  input  logic signed [CoordBits-1:0]   lo_i [3],
  input  logic signed [CoordBits-1:0]   hi_i [3],
  input  logic [CoordBits-2:0]          radius_i,
  output logic                          vld_o,
  output sbc_pkg::item_flags_t          flags_o,
  output logic [sbc_pkg::LEN2_W-1:0]    len2_o,
  output logic [2:0][sbc_pkg::A_W-1:0]  amag_o,
  output logic [2:0]                    sgn_o,
  output logic signed [CoordBits-1:0]   ctr_o [3],
  output logic signed [CoordBits-1:0]   pnt_o [3],
  output logic [CoordBits-2:0]          radius_o
);

  localparam int CB   = CoordBits;
  localparam int VW   = CB + 2;
  localparam int MW   = CB + 1;
  localparam int SQW  = 2 * CB - 2;
  localparam int SUMW = 2 * CB;
  localparam int TOPW = $clog2(CB + 1);
  localparam int SHW  = MW + sbc_pkg::NormTop;
  localparam int AW   = sbc_pkg::A_W;

  // ---------------- stage 1: classify and clamp ----------------
  logic [2:0]            below, above, far;
  logic signed [CB-1:0]  pnt_d [3];
  logic signed [CB:0]    dd [3];
  logic [CB:0]           dmag [3];
  logic signed [VW-1:0]  vv [3];
  logic signed [VW-1:0]  vec_d [3];
  logic                  outside_d;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      below[i] = ctr_i[i] < lo_i[i];
      above[i] = !below[i] && (ctr_i[i] > hi_i[i]);
      pnt_d[i] = below[i] ? lo_i[i] : (above[i] ? hi_i[i] : ctr_i[i]);
      dd[i]    = {ctr_i[i][CB-1], ctr_i[i]} - {pnt_d[i][CB-1], pnt_d[i]};
      dmag[i]  = dd[i][CB] ? MW'(-dd[i]) : MW'(dd[i]);
      far[i]   = dmag[i] > {2'b00, radius_i};
      vv[i]    = {ctr_i[i][CB-1], ctr_i[i], 1'b0}
               - {{2{lo_i[i][CB-1]}}, lo_i[i]}
               - {{2{hi_i[i][CB-1]}}, hi_i[i]};
    end
    outside_d = |(below | above);
    for (int i = 0; i < 3; i++) begin
      vec_d[i] = outside_d ? {dd[i][CB], dd[i]} : vv[i];
    end
  end

  logic                  s1_vld_q;
  logic signed [CB-1:0]  s1_ctr_q [3];
  logic signed [CB-1:0]  s1_pnt_q [3];
  logic signed [VW-1:0]  s1_vec_q [3];
  logic [CB-2:0]         s1_dml_q [3];
  logic                  s1_far_q, s1_out_q;
  logic [CB-2:0]         s1_rad_q;

  // ---------------- stage 2: squares and magnitudes ----------------
  logic [SQW-1:0] sq_d [3];
  logic [SQW-1:0] rsq_d;
  logic [MW-1:0]  am_d [3];
  logic [2:0]     sgn_d;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_d[i]  = SQW'(s1_dml_q[i] * s1_dml_q[i]);
      sgn_d[i] = s1_vec_q[i][VW-1];
      am_d[i]  = sgn_d[i] ? MW'(-s1_vec_q[i]) : MW'(s1_vec_q[i]);
    end
    rsq_d = SQW'(s1_rad_q * s1_rad_q);
  end

  logic                  s2_vld_q;
  logic [SQW-1:0]        s2_sq_q [3];
  logic [SQW-1:0]        s2_rsq_q;
  logic [MW-1:0]         s2_am_q [3];
  logic [2:0]            s2_sgn_q;
  logic                  s2_far_q, s2_out_q;
  logic signed [CB-1:0]  s2_ctr_q [3];
  logic signed [CB-1:0]  s2_pnt_q [3];
  logic [CB-2:0]         s2_rad_q;

  // ---------------- stage 3: distance compare and largest component ----------------
  logic [SUMW-1:0] sum_d;
  logic            miss_d;
  logic [MW-1:0]   mx01, mx_d;

  always_comb begin
    sum_d  = SUMW'(s2_sq_q[0]) + SUMW'(s2_sq_q[1]) + SUMW'(s2_sq_q[2]);
    miss_d = s2_far_q || (s2_out_q && (sum_d > SUMW'(s2_rsq_q)));
    mx01   = (s2_am_q[1] > s2_am_q[0]) ? s2_am_q[1] : s2_am_q[0];
    mx_d   = (s2_am_q[2] > mx01) ? s2_am_q[2] : mx01;
  end

  logic                  s3_vld_q;
  logic                  s3_miss_q, s3_in_q;
  logic [MW-1:0]         s3_am_q [3];
  logic [MW-1:0]         s3_mx_q;
  logic [2:0]            s3_sgn_q;
  logic signed [CB-1:0]  s3_ctr_q [3];
  logic signed [CB-1:0]  s3_pnt_q [3];
  logic [CB-2:0]         s3_rad_q;

  // ---------------- stage 4: prescale so the largest sits at NormTop ----------------
  logic [TOPW-1:0] top_d;
  logic [SHW-1:0]  shx [3];
  logic [AW-1:0]   a_d [3];

  always_comb begin
    top_d = '0;
    for (int b = 0; b < MW; b++) begin
      if (s3_mx_q[b]) top_d = TOPW'(b);
    end
    for (int i = 0; i < 3; i++) begin
      shx[i] = {s3_am_q[i], sbc_pkg::NormTop'(0)} >> top_d;
      a_d[i] = shx[i][AW-1:0];
    end
  end

  logic                  s4_vld_q;
  sbc_pkg::item_flags_t  s4_flags_q;
  logic [AW-1:0]         s4_a_q [3];
  logic [2:0]            s4_sgn_q;
  logic signed [CB-1:0]  s4_ctr_q [3];
  logic signed [CB-1:0]  s4_pnt_q [3];
  logic [CB-2:0]         s4_rad_q;

  // ---------------- stage 5: component squares ----------------
  logic                  s5_vld_q;
  sbc_pkg::item_flags_t  s5_flags_q;
  logic [2*AW-1:0]       s5_asq_q [3];
  logic [AW-1:0]         s5_a_q [3];
  logic [2:0]            s5_sgn_q;
  logic signed [CB-1:0]  s5_ctr_q [3];
  logic signed [CB-1:0]  s5_pnt_q [3];
  logic [CB-2:0]         s5_rad_q;

  // ---------------- stage 6: squared length ----------------
  logic                  s6_vld_q;
  sbc_pkg::item_flags_t  s6_flags_q;
  logic [sbc_pkg::LEN2_W-1:0] s6_len2_q;
  logic [AW-1:0]         s6_a_q [3];
  logic [2:0]            s6_sgn_q;
  logic signed [CB-1:0]  s6_ctr_q [3];
  logic signed [CB-1:0]  s6_pnt_q [3];
  logic [CB-2:0]         s6_rad_q;

  // Advance the valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
      s5_vld_q <= 1'b0;
      s6_vld_q <= 1'b0;
    end else if (adv_i) begin
      s1_vld_q <= vld_i;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
      s5_vld_q <= s4_vld_q;
      s6_vld_q <= s5_vld_q;
    end
  end

  // Advance the payload
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int i = 0; i < 3; i++) begin
        s1_ctr_q[i] <= ctr_i[i];
        s1_pnt_q[i] <= pnt_d[i];
        s1_vec_q[i] <= vec_d[i];
        s1_dml_q[i] <= dmag[i][CB-2:0];

        s2_sq_q[i]  <= sq_d[i];
        s2_am_q[i]  <= am_d[i];
        s2_ctr_q[i] <= s1_ctr_q[i];
        s2_pnt_q[i] <= s1_pnt_q[i];

        s3_am_q[i]  <= s2_am_q[i];
        s3_ctr_q[i] <= s2_ctr_q[i];
        s3_pnt_q[i] <= s2_pnt_q[i];

        s4_a_q[i]   <= a_d[i];
        s4_ctr_q[i] <= s3_ctr_q[i];
        s4_pnt_q[i] <= s3_pnt_q[i];

        s5_asq_q[i] <= (2*AW)'(s4_a_q[i] * s4_a_q[i]);
        s5_a_q[i]   <= s4_a_q[i];
        s5_ctr_q[i] <= s4_ctr_q[i];
        s5_pnt_q[i] <= s4_pnt_q[i];

        s6_a_q[i]   <= s5_a_q[i];
        s6_ctr_q[i] <= s5_ctr_q[i];
        s6_pnt_q[i] <= s5_pnt_q[i];
      end
      s1_far_q <= |far;
      s1_out_q <= outside_d;
      s1_rad_q <= radius_i;

      s2_rsq_q <= rsq_d;
      s2_sgn_q <= sgn_d;
      s2_far_q <= s1_far_q;
      s2_out_q <= s1_out_q;
      s2_rad_q <= s1_rad_q;

      s3_miss_q <= miss_d;
      s3_in_q   <= !s2_out_q;
      s3_mx_q   <= mx_d;
      s3_sgn_q  <= s2_sgn_q;
      s3_rad_q  <= s2_rad_q;

      s4_flags_q.miss     <= s3_miss_q;
      s4_flags_q.enclosed <= s3_in_q;
      s4_flags_q.zero     <= (s3_mx_q == '0);
      s4_sgn_q            <= s3_sgn_q;
      s4_rad_q            <= s3_rad_q;

      s5_flags_q <= s4_flags_q;
      s5_sgn_q   <= s4_sgn_q;
      s5_rad_q   <= s4_rad_q;

      s6_flags_q <= s5_flags_q;
      s6_len2_q  <= sbc_pkg::LEN2_W'(s5_asq_q[0]) + sbc_pkg::LEN2_W'(s5_asq_q[1])
                  + sbc_pkg::LEN2_W'(s5_asq_q[2]);
      s6_sgn_q   <= s5_sgn_q;
      s6_rad_q   <= s5_rad_q;
    end
  end

  assign vld_o    = s6_vld_q;
  assign flags_o  = s6_flags_q;
  assign len2_o   = s6_len2_q;
  assign sgn_o    = s6_sgn_q;
  assign radius_o = s6_rad_q;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      amag_o[i] = s6_a_q[i];
      ctr_o[i]  = s6_ctr_q[i];
      pnt_o[i]  = s6_pnt_q[i];
    end
  end

endmodule

### hdl/sbc_sqrt.sv
// sbc_sqrt: pipelined floor square root, a few result bits per stage.
// Depends on sbc_pkg; carries an opaque sideband alongside.
module sbc_sqrt #(
  parameter int SbW = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        adv_i,
  input  logic                        vld_i,
  input  logic [sbc_pkg::LEN2_W-1:0]  rad_i,
  input  logic [SbW-1:0]              sb_i,
  output logic                        vld_o,
  output logic [sbc_pkg::ROOT_W-1:0]  root_o,
  output logic [SbW-1:0]              sb_o
);

  localparam int NSTG = sbc_pkg::SqrtStg;
  localparam int RW   = sbc_pkg::REM_W;
  localparam int TW   = sbc_pkg::ROOT_W;
  localparam int LW   = sbc_pkg::LEN2_W;

  logic [RW-1:0]  rem_q  [NSTG];
  logic [TW-1:0]  root_q [NSTG];
  logic [LW-1:0]  rad_q  [NSTG];
  logic [SbW-1:0] sb_q   [NSTG];
  logic           vld_q  [NSTG];

  for (genvar g = 0; g < NSTG; g++) begin : g_stg
    logic [RW-1:0]  rem_s, rem_n;
    logic [TW-1:0]  root_s, root_n;
    logic [LW-1:0]  rad_s, rad_n;
    logic [SbW-1:0] sb_s;
    logic           vld_s;

    if (g == 0) begin : g_src
      assign rem_s  = '0;
      assign root_s = '0;
      assign rad_s  = rad_i;
      assign sb_s   = sb_i;
      assign vld_s  = vld_i;
    end else begin : g_src
      assign rem_s  = rem_q[g-1];
      assign root_s = root_q[g-1];
      assign rad_s  = rad_q[g-1];
      assign sb_s   = sb_q[g-1];
      assign vld_s  = vld_q[g-1];
    end

    // Bring in two radicand bits, try the next root bit
    always_comb begin
      logic [RW-1:0] rem2;
      logic [RW-1:0] trial;
      rem_n  = rem_s;
      root_n = root_s;
      rad_n  = rad_s;
      for (int k = 0; k < sbc_pkg::SqrtSteps; k++) begin
        rem2  = {rem_n[RW-3:0], rad_n[LW-1 -: 2]};
        trial = {root_n, 2'b01};
        rad_n = {rad_n[LW-3:0], 2'b00};
        if (rem2 >= trial) begin
          rem_n  = rem2 - trial;
          root_n = {root_n[TW-2:0], 1'b1};
        end else begin
          rem_n  = rem2;
          root_n = {root_n[TW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else if (adv_i) begin
        vld_q[g] <= vld_s;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[g]  <= rem_n;
        root_q[g] <= root_n;
        rad_q[g]  <= rad_n;
        sb_q[g]   <= sb_s;
      end
    end
  end

  assign vld_o  = vld_q[NSTG-1];
  assign root_o = root_q[NSTG-1];
  assign sb_o   = sb_q[NSTG-1];

endmodule

### hdl/sbc_div.sv
// sbc_div: three-lane pipelined rounded divide, component * 2^14 / length.
// Depends on sbc_pkg; carries an opaque sideband alongside.
module sbc_div #(
  parameter int SbW = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  logic                          vld_i,
  input  logic [sbc_pkg::ROOT_W-1:0]    len_i,
  input  logic [2:0][sbc_pkg::A_W-1:0]  amag_i,
  input  logic [SbW-1:0]                sb_i,
  output logic                          vld_o,
  output logic [2:0][sbc_pkg::Q_W-1:0]  quo_o,
  output logic [SbW-1:0]                sb_o
);

  localparam int NSTG = sbc_pkg::DivStg;
  localparam int RW   = sbc_pkg::DREM_W;
  localparam int QW   = sbc_pkg::Q_W;
  localparam int LW   = sbc_pkg::ROOT_W;
  localparam int NW   = sbc_pkg::A_W + sbc_pkg::FracSh + 1;

  logic [2:0][RW-1:0] rem_q [NSTG];
  logic [2:0][QW-1:0] nb_q  [NSTG];
  logic [2:0][QW-1:0] quo_q [NSTG];
  logic [LW-1:0]      len_q [NSTG];
  logic [SbW-1:0]     sb_q  [NSTG];
  logic               vld_q [NSTG];

  for (genvar g = 0; g < NSTG; g++) begin : g_stg
    logic [2:0][RW-1:0] rem_s, rem_n;
    logic [2:0][QW-1:0] nb_s, nb_n, quo_s, quo_n;
    logic [LW-1:0]      len_s;
    logic [SbW-1:0]     sb_s;
    logic               vld_s;

    if (g == 0) begin : g_src
      // Form the rounded numerator and preload its top bits
      always_comb begin
        logic [NW-1:0] num;
        for (int l = 0; l < 3; l++) begin
          num      = {1'b0, amag_i[l], sbc_pkg::FracSh'(0)} + NW'(len_i >> 1);
          rem_s[l] = RW'(num >> QW);
          nb_s[l]  = num[QW-1:0];
          quo_s[l] = '0;
        end
      end
      assign len_s = len_i;
      assign sb_s  = sb_i;
      assign vld_s = vld_i;
    end else begin : g_src
      assign rem_s = rem_q[g-1];
      assign nb_s  = nb_q[g-1];
      assign quo_s = quo_q[g-1];
      assign len_s = len_q[g-1];
      assign sb_s  = sb_q[g-1];
      assign vld_s = vld_q[g-1];
    end

    // Restoring steps, one quotient bit each
    always_comb begin
      logic [RW-1:0] rem2;
      rem_n = rem_s;
      nb_n  = nb_s;
      quo_n = quo_s;
      for (int l = 0; l < 3; l++) begin
        for (int k = 0; k < sbc_pkg::DivSteps; k++) begin
          rem2     = {rem_n[l][RW-2:0], nb_n[l][QW-1]};
          nb_n[l]  = {nb_n[l][QW-2:0], 1'b0};
          if (rem2 >= {1'b0, len_s}) begin
            rem_n[l] = rem2 - {1'b0, len_s};
            quo_n[l] = {quo_n[l][QW-2:0], 1'b1};
          end else begin
            rem_n[l] = rem2;
            quo_n[l] = {quo_n[l][QW-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else if (adv_i) begin
        vld_q[g] <= vld_s;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[g] <= rem_n;
        nb_q[g]  <= nb_n;
        quo_q[g] <= quo_n;
        len_q[g] <= len_s;
        sb_q[g]  <= sb_s;
      end
    end
  end

  assign vld_o = vld_q[NSTG-1];
  assign quo_o = quo_q[NSTG-1];
  assign sb_o  = sb_q[NSTG-1];

endmodule

### hdl/sphere_box_contact.sv
// sphere_box_contact: sphere versus axis-aligned box contact point and normal.
// Stages from input transfer to result: 6 prep, 5 root, 5 divide, 2 out.
// Throughput: one pair per cycle; a stalled output register freezes the whole pipe.
// Reset (rst_ni, async, active low) clears all valid bits; data registers are not reset.
// Depends on sbc_pkg, sbc_front, sbc_sqrt, sbc_div.
module sphere_box_contact #(
  parameter int COORD_BITS = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  // sphere_x, sphere_y, sphere_z, radius, box_min_x/y/z, box_max_x/y/z
  input  logic [((10*COORD_BITS-1+7)/8)*8-1:0] s_axis_tdata,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // contact_x, contact_y, contact_z, normal_x, normal_y, normal_z
  output logic [((3*COORD_BITS+48+7)/8)*8-1:0] m_axis_tdata,
  // hit, center_inside
  output logic [1:0]                           m_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready
);

  localparam int CB    = COORD_BITS;
  localparam int OUT_W = ((3*CB+48+7)/8)*8;
  localparam int AW    = sbc_pkg::A_W;
  localparam int QW    = sbc_pkg::Q_W;
  localparam int NW    = sbc_pkg::NRM_W;
  localparam int FW    = $bits(sbc_pkg::item_flags_t);
  localparam int SB2_W = 6*CB + (CB-1) + FW + 3;
  localparam int SB1_W = SB2_W + 3*AW;
  localparam int PW    = QW + CB - 1;
  localparam int SW    = CB + 2;

  logic adv;
  logic out_vld_q;

  // Move the whole pipe whenever the output register can take a result
  assign adv           = !out_vld_q || m_axis_tready;
  assign s_axis_tready = adv;

  // Unpack the input transfer
  logic signed [CB-1:0] ctr_in [3];
  logic signed [CB-1:0] lo_in  [3];
  logic signed [CB-1:0] hi_in  [3];
  logic [CB-2:0]        rad_in;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ctr_in[i] = s_axis_tdata[i*CB +: CB];
      lo_in[i]  = s_axis_tdata[4*CB-1 + i*CB +: CB];
      hi_in[i]  = s_axis_tdata[7*CB-1 + i*CB +: CB];
    end
    rad_in = s_axis_tdata[3*CB +: CB-1];
  end

  // Prep stages
  logic                       fr_vld;
  sbc_pkg::item_flags_t       fr_flags;
  logic [sbc_pkg::LEN2_W-1:0] fr_len2;
  logic [2:0][AW-1:0]         fr_amag;
  logic [2:0]                 fr_sgn;
  logic signed [CB-1:0]       fr_ctr [3];
  logic signed [CB-1:0]       fr_pnt [3];
  logic [CB-2:0]              fr_rad;

  sbc_front #(.CoordBits(CB)) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .vld_i    (s_axis_tvalid),
    .ctr_i    (ctr_in),
    .lo_i     (lo_in),
    .hi_i     (hi_in),
    .radius_i (rad_in),
    .vld_o    (fr_vld),
    .flags_o  (fr_flags),
    .len2_o   (fr_len2),
    .amag_o   (fr_amag),
    .sgn_o    (fr_sgn),
    .ctr_o    (fr_ctr),
    .pnt_o    (fr_pnt),
    .radius_o (fr_rad)
  );

  // Square root of the scaled length
  logic [SB1_W-1:0]            sq_sb_in, sq_sb_out;
  logic                        sq_vld;
  logic [sbc_pkg::ROOT_W-1:0]  sq_root;

  assign sq_sb_in = {fr_ctr[2], fr_ctr[1], fr_ctr[0], fr_pnt[2], fr_pnt[1], fr_pnt[0],
                     fr_rad, fr_flags, fr_sgn, fr_amag};

  sbc_sqrt #(.SbW(SB1_W)) u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .vld_i  (fr_vld),
    .rad_i  (fr_len2),
    .sb_i   (sq_sb_in),
    .vld_o  (sq_vld),
    .root_o (sq_root),
    .sb_o   (sq_sb_out)
  );

  // Divide each component by the length
  logic [SB2_W-1:0]    dv_sb_out;
  logic                dv_vld;
  logic [2:0][QW-1:0]  dv_quo;

  sbc_div #(.SbW(SB2_W)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .vld_i  (sq_vld),
    .len_i  (sq_root),
    .amag_i (sq_sb_out[3*AW-1:0]),
    .sb_i   (sq_sb_out[SB1_W-1:3*AW]),
    .vld_o  (dv_vld),
    .quo_o  (dv_quo),
    .sb_o   (dv_sb_out)
  );

  // Unpack the sideband after the divider
  logic signed [CB-1:0]  dv_ctr [3];
  logic signed [CB-1:0]  dv_pnt [3];
  logic [CB-2:0]         dv_rad;
  sbc_pkg::item_flags_t  dv_flags;
  logic [2:0]            dv_sgn;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dv_ctr[i] = dv_sb_out[SB2_W-3*CB + i*CB +: CB];
      dv_pnt[i] = dv_sb_out[SB2_W-6*CB + i*CB +: CB];
    end
    dv_rad   = dv_sb_out[FW+3 +: CB-1];
    dv_flags = dv_sb_out[3 +: FW];
    dv_sgn   = dv_sb_out[2:0];
  end

  // Stage: signed normal and offset product
  logic                  ps_vld_q;
  sbc_pkg::item_flags_t  ps_flags_q;
  logic signed [NW-1:0]  ps_nrm_q [3];
  logic [PW-1:0]         ps_prod_q [3];
  logic [2:0]            ps_sgn_q;
  logic signed [CB-1:0]  ps_ctr_q [3];
  logic signed [CB-1:0]  ps_pnt_q [3];

  logic signed [NW-1:0]  nrm_d [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dv_flags.zero) begin
        nrm_d[i] = '0;
      end else if (dv_sgn[i]) begin
        nrm_d[i] = -{1'b0, dv_quo[i]};
      end else begin
        nrm_d[i] = {1'b0, dv_quo[i]};
      end
    end
  end

  // Stage: contact select, round, saturate
  logic [CB:0]           off [3];
  logic signed [SW-1:0]  sum [3];
  logic signed [CB-1:0]  sat [3];
  logic signed [CB-1:0]  cnt_d [3];
  logic signed [NW-1:0]  nrm_o [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      off[i] = (CB+1)'(((PW+1)'(ps_prod_q[i]) + (PW+1)'(sbc_pkg::RndHalf))
                       >> sbc_pkg::FracSh);
      sum[i] = ps_sgn_q[i] ? {{2{ps_ctr_q[i][CB-1]}}, ps_ctr_q[i]} - {1'b0, off[i]}
                           : {{2{ps_ctr_q[i][CB-1]}}, ps_ctr_q[i]} + {1'b0, off[i]};
      if (sum[i][SW-1:CB-1] == '0 || sum[i][SW-1:CB-1] == '1) begin
        sat[i] = sum[i][CB-1:0];
      end else if (sum[i][SW-1]) begin
        sat[i] = {1'b1, {(CB-1){1'b0}}};
      end else begin
        sat[i] = {1'b0, {(CB-1){1'b1}}};
      end
      if (ps_flags_q.miss) begin
        cnt_d[i] = '0;
        nrm_o[i] = '0;
      end else begin
        cnt_d[i] = ps_flags_q.enclosed ? sat[i] : ps_pnt_q[i];
        nrm_o[i] = ps_nrm_q[i];
      end
    end
  end

  // Output register
  logic signed [CB-1:0]  out_cnt_q [3];
  logic signed [NW-1:0]  out_nrm_q [3];
  logic                  out_hit_q, out_in_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ps_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      ps_vld_q  <= dv_vld;
      out_vld_q <= ps_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        ps_nrm_q[i]  <= nrm_d[i];
        // A zero vector has a zero normal, so its offset is zero too
        ps_prod_q[i] <= dv_flags.zero ? '0 : PW'(dv_quo[i] * dv_rad);
        ps_ctr_q[i]  <= dv_ctr[i];
        ps_pnt_q[i]  <= dv_pnt[i];
        out_cnt_q[i] <= cnt_d[i];
        out_nrm_q[i] <= nrm_o[i];
      end
      ps_flags_q <= dv_flags;
      ps_sgn_q   <= dv_sgn;
      out_hit_q  <= !ps_flags_q.miss;
      out_in_q   <= !ps_flags_q.miss && ps_flags_q.enclosed;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = {out_in_q, out_hit_q};
  assign m_axis_tdata  = OUT_W'({out_nrm_q[2], out_nrm_q[1], out_nrm_q[0],
                                 out_cnt_q[2], out_cnt_q[1], out_cnt_q[0]});

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// testbench: streaming check of sphere_box_contact against a built-in contact predictor.
// Depends on sphere_box_contact (hdl) and its package sbc_pkg.
module testbench;

  localparam int CB    = 32;
  localparam int IN_W  = ((10*CB-1+7)/8)*8;
  localparam int OUT_W = ((3*CB+48+7)/8)*8;
  localparam int LIMIT = 20000;
  localparam longint CMAXV = 64'sd2147483647;
  localparam longint CMINV = -64'sd2147483648;

  typedef struct packed {
    logic [15:0] nz, ny, nx;
    logic [31:0] pz, py, px;
    logic [1:0]  flags;
  } contact_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic [IN_W-1:0]  s_axis_tdata = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [OUT_W-1:0] m_axis_tdata;
  logic [1:0]       m_axis_tuser;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;

  logic [IN_W-1:0] pair_q[$];
  contact_t        contact_q[$];
  int errors = 0, pairs_sent = 0, hits_seen = 0, results_seen = 0;
  int send_idle = 0, recv_idle = 0, hold_cycles = 0, quiet = 0;
  bit stim_done = 1'b0;
  bit in_taken = 1'b0;

  sphere_box_contact #(.COORD_BITS(CB)) DUT (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic longint unsigned magnitude(longint v);
    return v < 0 ? longint'(0) - v : v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // Scale so the largest magnitude tops at bit 23, then do a rounded divide by the floor-root length
  function automatic void unit_vector(input longint v[3], output longint n[3]);
    longint unsigned a[3], mx, len2, len, q;
    int top;
    mx = 0;
    len2 = 0;
    top = 0;
    for (int i = 0; i < 3; i++) begin
      a[i] = magnitude(v[i]);
      if (a[i] > mx) mx = a[i];
    end
    if (mx == 0) begin
      n[0] = 0; n[1] = 0; n[2] = 0;
      return;
    end
    while (top < 63 && (mx >> (top + 1)) != 0) top++;
    for (int i = 0; i < 3; i++) begin
      if (top > 23) a[i] >>= (top - 23);
      else a[i] <<= (23 - top);
      len2 += a[i] * a[i];
    end
    len = int_sqrt(len2);
    for (int i = 0; i < 3; i++) begin
      q = (a[i] * 16384 + len / 2) / len;
      n[i] = v[i] < 0 ? -longint'(q) : longint'(q);
    end
  endfunction

  function automatic contact_t predict_contact(logic [IN_W-1:0] d);
    longint c[3], lo[3], hi[3], p[3], dv[3], n[3], off, s;
    longint unsigned dm, r;
    logic [127:0] sq, r2;
    bit outside;
    contact_t res;
    res = '0;
    sq = '0;
    outside = 1'b0;
    r = 64'(d[126:96]);
    for (int i = 0; i < 3; i++) begin
      c[i]  = longint'($signed(d[32*i +: 32]));
      lo[i] = longint'($signed(d[127+32*i +: 32]));
      hi[i] = longint'($signed(d[223+32*i +: 32]));
    end
    for (int i = 0; i < 3; i++) begin
      p[i] = c[i];
      if (c[i] < lo[i]) p[i] = lo[i];
      else if (c[i] > hi[i]) p[i] = hi[i];
      dv[i] = c[i] - p[i];
      if (dv[i] != 0) begin
        dm = magnitude(dv[i]);
        outside = 1'b1;
        if (dm > r) return res;
        sq += 128'(dm) * 128'(dm);
      end
    end
    if (!outside) begin
      for (int i = 0; i < 3; i++) dv[i] = 2 * c[i] - lo[i] - hi[i];
      unit_vector(dv, n);
      for (int i = 0; i < 3; i++) begin
        off = longint'((magnitude(n[i]) * r + 8192) >> 14);
        s = c[i] + (n[i] < 0 ? -off : off);
        if (s > CMAXV) s = CMAXV;
        if (s < CMINV) s = CMINV;
        p[i] = s;
      end
      res.flags = 2'b11;
    end else begin
      r2 = 128'(r) * 128'(r);
      if (sq > r2) return res;
      unit_vector(dv, n);
      res.flags = 2'b01;
    end
    res.px = p[0][31:0]; res.py = p[1][31:0]; res.pz = p[2][31:0];
    res.nx = n[0][15:0]; res.ny = n[1][15:0]; res.nz = n[2][15:0];
    return res;
  endfunction

  function automatic logic [IN_W-1:0] pack_pair(logic [31:0] cx, logic [31:0] cy,
      logic [31:0] cz, logic [30:0] r, logic [31:0] x0, logic [31:0] y0, logic [31:0] z0,
      logic [31:0] x1, logic [31:0] y1, logic [31:0] z1);
    logic [IN_W-1:0] d;
    d = '0;
    d[318:0] = {z1, y1, x1, z0, y0, x0, r, cz, cy, cx};
    return d;
  endfunction

  // Random coordinate, mostly small so hits and near misses are common
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom_range(0, 8*65536)) - 4*65536);
    endcase
  endfunction

  function automatic logic [IN_W-1:0] random_pair();
    logic [31:0] c[3], a[3], b[3];
    logic [30:0] r;
    for (int i = 0; i < 3; i++) begin
      c[i] = rand_coord();
      a[i] = rand_coord();
      b[i] = rand_coord();
      if ($urandom_range(0, 7) != 0 && $signed(a[i]) > $signed(b[i])) begin
        c[i] = a[i]; a[i] = b[i]; b[i] = c[i];
        c[i] = rand_coord();
      end
      if ($urandom_range(0, 3) == 0) c[i] = a[i] + ((b[i] - a[i]) >> 1);
    end
    case ($urandom_range(0, 5))
      0: r = 31'($urandom);
      1: r = $urandom_range(0, 1) ? 31'h7fffffff : 31'h0;
      default: r = 31'($urandom_range(0, 4*65536));
    endcase
    return pack_pair(c[0], c[1], c[2], r, a[0], a[1], a[2], b[0], b[1], b[2]);
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("mismatch at result %0d: %s got %0h want %0h", results_seen, what, got, want);
  endtask

  // Driver: offer queued pairs and drive the output ready at the falling edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || in_taken) begin
        in_taken = 1'b0;
        if (pair_q.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= pair_q.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= $urandom_range(0, 99) >= recv_idle;
      end
    end
  end

  // Monitor: record input transfers and sample results at the rising edge
  always @(posedge clk_i) begin
    contact_t got, want;
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet <= 0;
      end else begin
        quiet <= quiet + 1;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        contact_q.push_back(predict_contact(s_axis_tdata));
        pairs_sent++;
        in_taken = 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        got = {m_axis_tdata[3*CB+47:0], m_axis_tuser};
        if (contact_q.size() == 0) begin
          report_mismatch("unexpected result", 0, 0);
        end else begin
          want = contact_q.pop_front();
          if (want.flags[0]) hits_seen++;
          if (got.flags[0] !== want.flags[0]) report_mismatch("hit", got.flags[0], want.flags[0]);
          if (got.flags[1] !== want.flags[1])
            report_mismatch("center_inside", got.flags[1], want.flags[1]);
          if (got.px !== want.px) report_mismatch("contact_x", got.px, want.px);
          if (got.py !== want.py) report_mismatch("contact_y", got.py, want.py);
          if (got.pz !== want.pz) report_mismatch("contact_z", got.pz, want.pz);
          if (got.nx !== want.nx) report_mismatch("normal_x", got.nx, want.nx);
          if (got.ny !== want.ny) report_mismatch("normal_y", got.ny, want.ny);
          if (got.nz !== want.nz) report_mismatch("normal_z", got.nz, want.nz);
        end
      end
      if (quiet >= LIMIT) begin
        $display("timeout: no transfer for %0d cycles", LIMIT);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic wait_drained();
    while (pair_q.size() != 0 || s_axis_tvalid || contact_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    logic [31:0] u;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // Directed: inside, center at box center, faces, edges, corners, extremes
    u = 32'h00010000;
    pair_q.push_back(pack_pair(0, 0, 0, 31'h8000, -u, -u, -u, u, u, u));
    pair_q.push_back(pack_pair(u>>1, 0, 0, 31'h10000, -u, -u, -u, u, u, u));
    pair_q.push_back(pack_pair(-u, u, u, 31'h10000, -u, -u, -u, u, u, u));
    pair_q.push_back(pack_pair(2*u, 0, 0, 31'h10000, -u, -u, -u, u, u, u));
    pair_q.push_back(pack_pair(2*u+1, 0, 0, 31'h10000, -u, -u, -u, u, u, u));
    pair_q.push_back(pack_pair(-2*u, 2*u, 0, 31'h20000, -u, -u, -u, u, u, u));
    pair_q.push_back(pack_pair(-2*u, 2*u, 0, 31'h16a09, -u, -u, -u, u, u, u));
    pair_q.push_back(pack_pair(2*u, 2*u, -2*u, 31'h20000, -u, -u, -u, u, u, u));
    pair_q.push_back(pack_pair(2*u, 2*u, -2*u, 31'h1bb67, -u, -u, -u, u, u, u));
    pair_q.push_back(pack_pair(0, 0, 0, 31'h7fffffff, -u, -u, -u, u, u, u));
    pair_q.push_back(pack_pair(32'h7ffffff0, 0, 0, 31'h7fffffff,
        32'h80000000, -u, -u, 32'h7fffffff, u, u));
    pair_q.push_back(pack_pair(32'h80000000, 32'h7fffffff, 0, 31'h7fffffff,
        32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
    pair_q.push_back(pack_pair(32'h80000000, 0, 0, 31'h7fffffff,
        32'h7fffffff, 0, 0, 32'h7fffffff, 0, 0));
    pair_q.push_back(pack_pair(0, 0, 0, 31'h0, 0, 0, 0, 0, 0, 0));
    pair_q.push_back(pack_pair(0, 0, 0, 31'h0, u, u, u, -u, -u, -u));
    pair_q.push_back(pack_pair(32'hffffffff, 32'hffffffff, 32'hffffffff, 31'h7fffffff,
        32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff));
    pair_q.push_back(pack_pair(3, -7, 11, 31'h40, 0, 0, 0, 1, 1, 1));
    wait_drained();

    // Random traffic under three idling profiles
    send_idle = 30; recv_idle = 72;
    repeat (550) pair_q.push_back(random_pair());
    wait_drained();
    send_idle = 72; recv_idle = 30;
    repeat (550) pair_q.push_back(random_pair());
    @(negedge clk_i) hold_cycles = 200;
    wait_drained();
    send_idle = 0; recv_idle = 0;
    repeat (300) pair_q.push_back(random_pair());
    @(negedge clk_i) hold_cycles = 150;
    wait_drained();
    repeat (280) pair_q.push_back(random_pair());
    wait_drained();
    repeat (40) @(posedge clk_i);

    $display("covered %0d sphere/box pairs, %0d hits, under idle, stall and back-pressure",
        pairs_sent, hits_seen);
    if (errors == 0 && contact_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
